// ===== rtl/core/ipme_pkg.sv =====
// Shared types and constants of the icon pixel and mask encoder.
package ipme_pkg;

	// configuration port
	localparam int PADDR_W = 4;
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_PIXEL_MODE  = 2'd0;
	localparam reg_idx_t REG_OPAQUE_MODE = 2'd1;
	localparam reg_idx_t REG_ROW_WIDTH   = 2'd2;

	typedef enum logic [1:0] {
		MODE_PACK4,
		MODE_INDEX8,
		MODE_EXPAND,
		MODE_DIRECT
	} pix_mode_t;

	// item opcodes
	localparam logic OP_PAL_WRITE = 1'b0;
	localparam logic OP_PIXEL     = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_COLOR = 2'd0;
	localparam logic [1:0] KIND_MASK  = 2'd1;
	localparam logic [1:0] KIND_PAD   = 2'd2;

	localparam logic [7:0] NIBBLE_LIMIT = 8'd16;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam int         MASK_BITS    = 8;
	localparam int         ROW_ALIGN    = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SEARCH,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_BUILD,
		ST_EMIT
	} ctl_state_t;

	// one palette entry presented to the nearest-colour search
	typedef struct packed {
		logic       vld;
		logic       first;
		logic [3:0] index;
	} srch_beat_t;

endpackage

// ===== rtl/core/ipme_in_if.sv =====
// Input channel: palette writes and pixels.
interface ipme_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  entry_index;
	logic [31:0] entry_color;
	logic [31:0] pixel_value;
	logic        first_of_image;

	modport source(output valid, op, entry_index, entry_color, pixel_value, first_of_image,
		input ready);
	modport sink(input valid, op, entry_index, entry_color, pixel_value, first_of_image,
		output ready);
endinterface

// ===== rtl/core/ipme_out_if.sv =====
// Output channel: colour data, mask bytes and mask padding.
interface ipme_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] data_word;
	logic        key_error;
	logic        last;

	modport source(output valid, kind, data_word, key_error, last, input ready);
	modport sink(input valid, kind, data_word, key_error, last, output ready);
endinterface

// ===== rtl/core/ipme_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ipme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/ipme_nearest.sv =====
// Nearest-colour search: squared BGR distance per entry, keep the lowest.
module ipme_nearest
	import ipme_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  srch_beat_t  beat,
	input  logic [31:0] find,
	input  logic [31:0] color,
	output logic [3:0]  best
);
	logic [7:0]  dif [3];
	logic [15:0] sq [3];
	logic [17:0] dist_sum;
	logic [17:0] dist_s2;
	srch_beat_t  beat_s2;
	logic [17:0] best_d_q;
	logic [3:0]  best_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (find[8*c +: 8] > color[8*c +: 8]) begin
				dif[c] = find[8*c +: 8] - color[8*c +: 8];
			end else begin
				dif[c] = color[8*c +: 8] - find[8*c +: 8];
			end
			sq[c] = 16'(dif[c]) * 16'(dif[c]);
		end
		dist_sum = 18'(sq[0]) + 18'(sq[1]) + 18'(sq[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s2 <= '0;
			best_q  <= '0;
		end else begin
			beat_s2 <= beat;
			// strict compare: the lowest entry wins a tie
			if (beat_s2.vld && (beat_s2.first || dist_s2 < best_d_q)) begin
				best_q <= beat_s2.index;
			end
		end
	end

	always_ff @(posedge clk) begin
		dist_s2 <= dist_sum;
		if (beat_s2.vld && (beat_s2.first || dist_s2 < best_d_q)) begin
			best_d_q <= dist_s2;
		end
	end

	assign best = best_q;
endmodule

// ===== rtl/core/icon_pixel_and_mask_encoder_unit.sv =====
// Top level of the icon pixel and AND-mask encoder.
//
//  channel   dir  handshake            carries
//  pix_in    in   valid/ready          palette write or pixel item
//  res_out   out  valid/ready          colour, mask or padding result item
//  apb       in   psel/penable/pwrite  pixel_mode, opaque_mode, row_width
//
// A palette write is taken in the idle state. A pixel passes accept, palette
// fetch and build, then emits each result it causes; a 4-bit pixel with index of
// 16 or more adds a search over MATCH_ENTRIES entries, read one per cycle
// through the single palette read port, and two drain states.
// Reset clears control state and control registers; the palette is undefined until
// written, so it gets no clearing pass. Results leave through an output register,
// so a stalled sink holds one result while the next item can be taken.
module icon_pixel_and_mask_encoder_unit
	import ipme_pkg::*;
#(
	parameter int PALETTE_DEPTH = 256,
	parameter int MATCH_ENTRIES = 16,
	parameter int MAX_WIDTH     = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	ipme_in_if.sink            pix_in,
	ipme_out_if.source         res_out
);
	localparam int AW      = $clog2(PALETTE_DEPTH);
	localparam int MW      = $clog2(MATCH_ENTRIES);
	localparam int MaxWRaw = (MAX_WIDTH / MASK_BITS) * MASK_BITS;
	localparam int MaxW    = (MaxWRaw < MASK_BITS) ? MASK_BITS : MaxWRaw;
	localparam logic [MW-1:0] MatchLast = MW'(MATCH_ENTRIES - 1);

	// configuration
	pix_mode_t  mode_q;
	logic       opaque_q;
	logic [8:0] row_width_q;
	logic       cfg_wr;

	// encoder state
	ctl_state_t state_q, state_d;
	logic [31:0] key_q;
	logic [8:0]  col_q;
	logic [7:0]  mask_q;
	logic [3:0]  nib_q;
	logic        nib_pend_q;
	logic [31:0] pix_q;
	logic [31:0] fetch_q;
	logic [MW-1:0] cnt_q;

	// palette access
	logic          in_fire;
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	logic [7:0]    rd_idx;
	logic [7:0]    rd_idx_s1;
	logic          rd_oob_s1;
	logic [31:0]   pal_val;
	srch_beat_t    srch_s1;
	logic [3:0]    best;

	// build
	logic [7:0]  idx;
	logic        bld_err;
	logic        bld_transp;
	logic [3:0]  bld_nib;
	logic [31:0] bld_color;
	logic        bld_has_color;
	logic [7:0]  bld_mask;
	logic [8:0]  bld_col;
	logic        bld_mask_emit;
	logic        bld_row_end;
	logic [8:0]  eff_w;
	logic [1:0]  pad_cnt;

	// pending results
	logic [31:0] color_q;
	logic        color_pend_q;
	logic        mask_pend_q;
	logic [7:0]  mask_byte_q;
	logic [1:0]  pads_q;
	logic        err_q;

	// emit and output register
	logic        out_load;
	logic [1:0]  e_kind;
	logic [31:0] e_data;
	logic        e_last;
	logic        ov_q;
	logic [1:0]  okind_q;
	logic [31:0] odata_q;
	logic        oerr_q;
	logic        olast_q;

	//------------------------------------------------------------------
	// Configuration port
	//------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[3:2])
			REG_PIXEL_MODE:  prdata = {30'b0, mode_q};
			REG_OPAQUE_MODE: prdata = {31'b0, opaque_q};
			REG_ROW_WIDTH:   prdata = {23'b0, row_width_q};
			default:         prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Palette memory and nearest-colour search
	//------------------------------------------------------------------
	assign in_fire = pix_in.valid & pix_in.ready;
	assign ram_we  = in_fire && (pix_in.op == OP_PAL_WRITE) &&
		({1'b0, pix_in.entry_index} < 9'(PALETTE_DEPTH));

	ipme_ram #(
		.WIDTH(32),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pix_in.entry_index[AW-1:0]),
		.wdata(pix_in.entry_color),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// the key's entry reads as zero unless opaque; so does an entry past the store
	assign pal_val = (rd_oob_s1 || (!opaque_q && rd_idx_s1 == key_q[7:0])) ? '0 : ram_rdata;

	ipme_nearest u_nearest (
		.clk   (clk),
		.arst_n(arst_n),
		.beat  (srch_s1),
		.find  (fetch_q),
		.color (pal_val),
		.best  (best)
	);

	//------------------------------------------------------------------
	// Build: colour, mask bit, row position
	//------------------------------------------------------------------
	always_comb begin
		eff_w = {row_width_q[8:3], 3'b000};
		if (eff_w < 9'(MASK_BITS)) begin
			eff_w = 9'(MASK_BITS);
		end
		if (eff_w > 9'(MaxW)) begin
			eff_w = 9'(MaxW);
		end
		// pad the row of mask bytes up to a multiple of four
		pad_cnt = 2'(2'd0 - eff_w[4:3]);
	end

	always_comb begin
		idx        = pix_q[7:0];
		bld_err    = (mode_q == MODE_PACK4) && (key_q[7:0] >= NIBBLE_LIMIT);
		if (mode_q == MODE_DIRECT) begin
			bld_transp = !opaque_q && (pix_q == key_q);
		end else begin
			bld_transp = !opaque_q && (idx == key_q[7:0]);
		end
		bld_nib = (idx >= NIBBLE_LIMIT) ? best : idx[3:0];

		case (mode_q)
			MODE_PACK4: begin
				bld_color     = {24'b0, nib_q, bld_nib};
				bld_has_color = nib_pend_q;
			end
			MODE_INDEX8: begin
				bld_color     = {24'b0, idx};
				bld_has_color = 1'b1;
			end
			MODE_EXPAND: begin
				bld_color     = {bld_transp ? 8'h00 : ALPHA_OPAQUE, fetch_q[23:0]};
				bld_has_color = 1'b1;
			end
			default: begin
				bld_color     = bld_transp ? '0 : pix_q;
				bld_has_color = 1'b1;
			end
		endcase

		bld_mask      = {mask_q[6:0], bld_transp};
		bld_col       = col_q + 9'd1;
		bld_mask_emit = (bld_col[2:0] == 3'd0);
		bld_row_end   = bld_mask_emit && (bld_col >= eff_w);
	end

	//------------------------------------------------------------------
	// Sequencer
	//------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && pix_in.op == OP_PIXEL) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (mode_q == MODE_PACK4 && pix_q[7:0] >= NIBBLE_LIMIT) begin
					state_d = ST_SEARCH;
				end else begin
					state_d = ST_BUILD;
				end
			end
			ST_SEARCH: begin
				if (cnt_q == MatchLast) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: state_d = ST_BUILD;
			ST_BUILD: begin
				if (bld_has_color || bld_mask_emit) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_load && e_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pix_in.ready = (state_q == ST_IDLE);
		// address the pixel's own entry at accept, the match entries during search
		if (state_q == ST_SEARCH) begin
			ram_raddr = AW'(cnt_q);
			rd_idx    = 8'(cnt_q);
		end else begin
			ram_raddr = pix_in.pixel_value[AW-1:0];
			rd_idx    = pix_in.pixel_value[7:0];
		end
		out_load = (state_q == ST_EMIT) && (!ov_q || res_out.ready);
		// emit order: colour, mask byte, then padding
		if (color_pend_q) begin
			e_kind = KIND_COLOR;
			e_data = color_q;
			e_last = !mask_pend_q;
		end else if (mask_pend_q) begin
			e_kind = KIND_MASK;
			e_data = {24'b0, mask_byte_q};
			e_last = (pads_q == 2'd0);
		end else begin
			e_kind = KIND_PAD;
			e_data = '0;
			e_last = (pads_q == 2'd1);
		end
	end

	//------------------------------------------------------------------
	// Control registers
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_PACK4;
			opaque_q     <= 1'b0;
			row_width_q  <= 9'd32;
			state_q      <= ST_IDLE;
			key_q        <= '0;
			col_q        <= '0;
			mask_q       <= '0;
			nib_q        <= '0;
			nib_pend_q   <= 1'b0;
			cnt_q        <= '0;
			srch_s1      <= '0;
			color_pend_q <= 1'b0;
			mask_pend_q  <= 1'b0;
			pads_q       <= '0;
			ov_q         <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_PIXEL_MODE:  mode_q      <= pix_mode_t'(pwdata[1:0]);
					REG_OPAQUE_MODE: opaque_q    <= pwdata[0];
					REG_ROW_WIDTH:   row_width_q <= pwdata[8:0];
					default: ;
				endcase
			end

			// first pixel of an image: capture the key, restart the row, drop a nibble
			if (in_fire && pix_in.op == OP_PIXEL && pix_in.first_of_image) begin
				key_q      <= pix_in.pixel_value;
				col_q      <= '0;
				mask_q     <= '0;
				nib_q      <= '0;
				nib_pend_q <= 1'b0;
			end

			if (state_q == ST_FETCH) begin
				cnt_q <= '0;
			end else if (state_q == ST_SEARCH) begin
				cnt_q <= cnt_q + MW'(1);
			end

			srch_s1.vld   <= (state_q == ST_SEARCH);
			srch_s1.first <= (cnt_q == '0);
			srch_s1.index <= 4'(cnt_q);

			if (state_q == ST_BUILD) begin
				mask_q       <= bld_mask_emit ? '0 : bld_mask;
				col_q        <= bld_row_end ? '0 : bld_col;
				if (mode_q == MODE_PACK4) begin
					if (nib_pend_q) begin
						nib_pend_q <= 1'b0;
					end else begin
						nib_q      <= bld_nib;
						nib_pend_q <= 1'b1;
					end
				end
				color_pend_q <= bld_has_color;
				mask_pend_q  <= bld_mask_emit;
				pads_q       <= bld_row_end ? pad_cnt : 2'd0;
			end else if (out_load) begin
				// advance to the next pending result
				if (color_pend_q) begin
					color_pend_q <= 1'b0;
				end else if (mask_pend_q) begin
					mask_pend_q <= 1'b0;
				end else begin
					pads_q <= pads_q - 2'd1;
				end
			end

			if (out_load) begin
				ov_q <= 1'b1;
			end else if (res_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	//------------------------------------------------------------------
	// Payload registers
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_q <= pix_in.pixel_value;
		end
		rd_idx_s1 <= rd_idx;
		rd_oob_s1 <= ({1'b0, rd_idx} >= 9'(PALETTE_DEPTH));
		if (state_q == ST_FETCH) begin
			fetch_q <= pal_val;
		end
		if (state_q == ST_BUILD) begin
			color_q     <= bld_color;
			mask_byte_q <= bld_mask;
			err_q       <= bld_err;
		end
		if (out_load) begin
			okind_q <= e_kind;
			odata_q <= e_data;
			oerr_q  <= err_q;
			olast_q <= e_last;
		end
	end

	assign res_out.valid     = ov_q;
	assign res_out.kind      = okind_q;
	assign res_out.data_word = odata_q;
	assign res_out.key_error = oerr_q;
	assign res_out.last      = olast_q;
endmodule
